@@ src/zvc_pkg.sv @@
// shared types, constants and zigzag helpers for the varint codec
package zvc_pkg;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   localparam logic KIND_BYTE  = 1'b0;
   localparam logic KIND_VALUE = 1'b1;

   localparam int unsigned GROUP_BITS = 7;
   localparam logic [3:0] ENC_MAX_CONT = 4'd9;
   localparam logic [3:0] DEC_MAX_IDX  = 4'd9;
   localparam logic [3:0] LIMIT_NARROW = 4'd5;
   localparam logic [3:0] LIMIT_WIDE   = 4'd10;

   typedef struct packed {
      logic        mode;
      logic        is_signed;
      logic        wide;
      logic [63:0] value;
      logic [7:0]  in_byte;
   } zvc_req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  out_byte;
      logic        last;
      logic [63:0] decoded_value;
   } zvc_rsp_type;

   // classified work item held in the queue; data is the mapped value
   // for an encode and carries the stream byte in its low bits for a decode
   typedef struct packed {
      logic        mode;
      logic        is_signed;
      logic        wide;
      logic [63:0] data;
   } zvc_cmd_type;

   function automatic logic [63:0] zz_map(input logic [63:0] x, input logic wide);
      logic [31:0] lo;
      begin
         lo = {x[30:0], 1'b0} ^ {32{x[31]}};
         if (wide) begin
            zz_map = {x[62:0], 1'b0} ^ {64{x[63]}};
         end else begin
            zz_map = {32'd0, lo};
         end
      end
   endfunction

   function automatic logic [63:0] zz_unmap(input logic [63:0] x, input logic wide);
      logic [63:0] r;
      begin
         r = {1'b0, x[63:1]} ^ {64{x[0]}};
         if (wide) begin
            zz_unmap = r;
         end else begin
            zz_unmap = {{32{r[31]}}, r[31:0]};
         end
      end
   endfunction

endpackage

@@ src/zvc_front.sv @@
// front end: classifies request items and prepares encode values
module zvc_front import zvc_pkg::*; (
   input  zvc_req_type req_item,
   output zvc_cmd_type cmd
);

   logic [63:0] trunc_value;

   always_comb begin
      trunc_value = req_item.wide ? req_item.value : {32'd0, req_item.value[31:0]};
      cmd.mode      = req_item.mode;
      cmd.is_signed = req_item.is_signed;
      cmd.wide      = req_item.wide;
      if (req_item.mode == MODE_ENCODE) begin
         cmd.data = req_item.is_signed ? zz_map(trunc_value, req_item.wide) : trunc_value;
      end else begin
         cmd.data = {56'd0, req_item.in_byte};
      end
   end

endmodule

@@ src/zvc_queue.sv @@
// two-entry command queue between front and back ends
module zvc_queue import zvc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  zvc_cmd_type push_cmd,
   output logic        full,
   input  logic        pop,
   output logic        head_valid,
   output zvc_cmd_type head_cmd
);

   zvc_cmd_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ src/zvc_back.sv @@
// back end: byte-serial encoder, decode accumulator and output register
module zvc_back import zvc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  zvc_cmd_type cmd,
   output logic        cmd_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output zvc_rsp_type rsp_data
);

   logic        rsp_valid_ff, rsp_valid_in;
   zvc_rsp_type rsp_data_ff, rsp_data_in;
   logic        enc_busy_ff, enc_busy_in;
   logic [63:0] enc_val_ff, enc_val_in;
   logic [3:0]  enc_cnt_ff, enc_cnt_in;
   logic [63:0] acc_ff, acc_in;
   logic [3:0]  idx_ff, idx_in;

   logic        out_free;
   logic [63:0] enc_cur;
   logic [3:0]  enc_n;
   logic        enc_cont;
   logic [3:0]  dec_k;
   logic [3:0]  dec_limit;
   logic [5:0]  shift_amt;
   logic [63:0] acc_merged;
   logic [63:0] dec_trunc;
   logic [7:0]  dec_byte;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cmd_pop   = cmd_valid && !enc_busy_ff && out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      // encoder works on either the held remainder or a fresh command
      enc_cur  = enc_busy_ff ? enc_val_ff : cmd.data;
      enc_n    = enc_busy_ff ? enc_cnt_ff : 4'd0;
      enc_cont = (|enc_cur[63:GROUP_BITS]) && (enc_n < ENC_MAX_CONT);

      dec_byte   = cmd.data[7:0];
      dec_k      = (idx_ff > DEC_MAX_IDX) ? DEC_MAX_IDX : idx_ff;
      dec_limit  = cmd.wide ? LIMIT_WIDE : LIMIT_NARROW;
      shift_amt  = 6'(dec_k) * 6'd7;
      acc_merged = acc_ff | ({57'd0, dec_byte[6:0]} << shift_amt);
      dec_trunc  = cmd.wide ? acc_merged : {32'd0, acc_merged[31:0]};

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      enc_busy_in  = enc_busy_ff;
      enc_val_in   = enc_val_ff;
      enc_cnt_in   = enc_cnt_ff;
      acc_in       = acc_ff;
      idx_in       = idx_ff;

      if (out_free && (enc_busy_ff || (cmd_valid && cmd.mode == MODE_ENCODE))) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.kind           = KIND_BYTE;
         rsp_data_in.decoded_value  = 64'd0;
         if (enc_cont) begin
            rsp_data_in.out_byte = {1'b1, enc_cur[6:0]};
            rsp_data_in.last     = 1'b0;
            enc_busy_in          = 1'b1;
            enc_val_in           = enc_cur >> GROUP_BITS;
            enc_cnt_in           = enc_n + 4'd1;
         end else begin
            rsp_data_in.out_byte = enc_cur[7:0];
            rsp_data_in.last     = 1'b1;
            enc_busy_in          = 1'b0;
         end
      end else if (out_free && cmd_valid) begin
         if (dec_byte[7] && ((dec_k + 4'd1) < dec_limit)) begin
            // continuation byte, nothing to emit yet
            acc_in = acc_merged;
            idx_in = dec_k + 4'd1;
         end else begin
            rsp_valid_in              = 1'b1;
            rsp_data_in.kind          = KIND_VALUE;
            rsp_data_in.out_byte      = 8'd0;
            rsp_data_in.last          = 1'b1;
            rsp_data_in.decoded_value = cmd.is_signed ? zz_unmap(dec_trunc, cmd.wide)
                                                      : dec_trunc;
            acc_in = 64'd0;
            idx_in = 4'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         enc_busy_ff  <= 1'b0;
         enc_cnt_ff   <= 4'd0;
         acc_ff       <= 64'd0;
         idx_ff       <= 4'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         enc_busy_ff  <= enc_busy_in;
         enc_cnt_ff   <= enc_cnt_in;
         acc_ff       <= acc_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      enc_val_ff  <= enc_val_in;
   end

endmodule

@@ src/zigzag_varint_codec.sv @@
// top level of the zigzag varint codec
// Encodes and decodes 7-bit little-endian varints (32- or 64-bit, optional
// zigzag mapping for signed values). A decode item carries one stream byte;
// it yields a result only on the byte that ends a varint. An encode item
// yields one to ten byte transfers, one per cycle while the output is not
// stalled, and holds the back end until its last byte; this byte-serial
// encoder sets the throughput. Requests go through a two-entry queue in
// front of the back end, so req_stall rises only when that queue is full,
// and results leave through an output register. Decoder state persists
// across interleaved encode items. A request passes through a queue entry
// and then the output register before its first result appears.
module zigzag_varint_codec import zvc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  zvc_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output zvc_rsp_type rsp_data
);

   zvc_cmd_type front_cmd;
   zvc_cmd_type head_cmd;
   logic        q_full;
   logic        head_valid;
   logic        head_pop;

   assign req_stall = q_full;

   zvc_front u_front (
      .req_item (req_data),
      .cmd      (front_cmd)
   );

   zvc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid),
      .push_cmd   (front_cmd),
      .full       (q_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   zvc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (head_valid),
      .cmd       (head_cmd),
      .cmd_pop   (head_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
